// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted list engine.
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is high.
`define SLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define SLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sle_pkg.sv =====
// Package for the sorted list engine: word types, operation and status codes.
// Depends on nothing.
package sle_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 8;
  localparam int OUT_CNT_W = 5;

  // Operation codes.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } item_t;

  // Output word.
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [OUT_CNT_W-1:0]    entry_count;
  } result_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } sle_cmd_t;

endpackage

// ===== rtl/sle_cell.sv =====
// One storage cell of the sorted row: holds one entry and shifts with its neighbors.
// Depends on sle_pkg.
module sle_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 5
) (
  input  logic                            clk,
  input  sle_pkg::sle_cmd_t               cmd,
  input  logic [CNT_W-1:0]                count,
  input  logic                            lt_left,
  input  logic signed [sle_pkg::VAL_W-1:0] left_entry,
  input  logic signed [sle_pkg::VAL_W-1:0] right_entry,
  output logic signed [sle_pkg::VAL_W-1:0] entry,
  output logic                            lt
);
  import sle_pkg::*;

  logic signed [VAL_W-1:0] entry_next;
  logic                    occupied;
  logic                    at_or_past;

  // The cell is occupied when its position lies below the count.
  assign occupied   = CNT_W'(POS) < count;
  assign at_or_past = (IDX_W + 1)'(POS) >= {1'b0, cmd.index};

  // Occupied entries smaller than the new value form a prefix of the row.
  assign lt = occupied && (entry < cmd.value);

  // Insert keeps smaller entries, drops the value at the boundary and shifts
  // the rest right; remove shifts everything at or past the index left.
  always_comb begin
    entry_next = entry;
    if (cmd.insert) begin
      if (!lt) begin
        entry_next = lt_left ? cmd.value : left_entry;
      end
    end else if (cmd.remove && at_or_past) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/sorted_list_engine.sv =====
// Sorted list engine: a row of CAPACITY cells keeps signed words in ascending order.
// Each accepted word gives its result word in the next cycle, from the result register;
// throughput is one word per cycle while results are taken, since the whole row shifts at once.
// A held result stalls the input until it is taken.
// Reset clears the entry count and the result valid; cell contents stay undefined.
// Depends on sle_pkg, sle_cell and assert_macros.svh.
`include "assert_macros.svh"

module sorted_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  sle_pkg::item_t   cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output sle_pkg::result_t rsp
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    fire;
  logic                    in_range;
  logic                    full;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] rd_data;
  sle_cmd_t                cell_cmd;

  logic signed [VAL_W-1:0] entry [CAPACITY];
  logic                    lt    [CAPACITY];

  // The output register parts the two sides; input waits only on a held result.
  assign cmd_stall = rsp_valid && rsp_stall;
  assign fire      = cmd_valid && !cmd_stall;
  assign in_range  = CMP_W'(cmd.index) < CMP_W'(count);
  assign full      = count == CNT_W'(CAPACITY);

  // Decode the operation into a status, a new count and a cell command.
  always_comb begin
    status          = ST_OK;
    count_next      = count;
    cell_cmd.insert = 1'b0;
    cell_cmd.remove = 1'b0;
    cell_cmd.value  = cmd.value;
    cell_cmd.index  = cmd.index;
    unique case (cmd.action)
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cell_cmd.insert = fire;
          count_next      = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!in_range) begin
          status = ST_RANGE;
        end else begin
          cell_cmd.remove = fire;
          count_next      = count - CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Read mux over the cell outputs.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(i) == CMP_W'(cmd.index)) begin
        rd_data = entry[i];
      end
    end
  end

  // Row of cells, each wired to its left and right neighbor; an end cell uses its own entry where it has none.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    lt_left;
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    if (g == 0) begin : g_first
      assign lt_left    = 1'b1;
      assign left_entry = entry[g];
    end else begin : g_inner
      assign lt_left    = lt[g-1];
      assign left_entry = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = entry[g];
    end else begin : g_body
      assign right_entry = entry[g+1];
    end

    sle_cell #(
      .POS   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .count       (count),
      .lt_left     (lt_left),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[g]),
      .lt          (lt[g])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_value  <= (cmd.action == ACT_READ && in_range) ? rd_data : '0;
      rsp.status      <= status;
      rsp.entry_count <= OUT_CNT_W'(count_next);
    end
  end

  // Reset empties the store and drops any pending result word.
  `SLE_ASSERT_ALWAYS(a_reset_clears, rst |=> count == '0 && !rsp_valid, "reset did not clear")
  // The count never exceeds the row length.
  `SLE_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count exceeds capacity")
  // An accepted insert into a store that is not full grows the count by one.
  `SLE_ASSERT(a_insert_grows, cell_cmd.insert |=> count == $past(count) + CNT_W'(1), "count not grown")
  // A full status is only shown while the store is full.
  `SLE_ASSERT(a_full_status, rsp_valid && rsp.status == ST_FULL |-> full, "full status with room left")
  // An empty status is only shown while the store is empty.
  `SLE_ASSERT(a_empty_status, rsp_valid && rsp.status == ST_EMPTY |-> count == '0, "empty status with entries stored")

endmodule

// ===== tb/sle_order_check.sv =====
// Checking side of the sorted list engine testbench: watches both word channels,
// keeps its own ordered list, and compares every result word with its prediction.
// Depends on sle_pkg.
module sle_order_check #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic             cmd_stall,
  input  sle_pkg::item_t   cmd,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  sle_pkg::result_t rsp,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  // Shadow copy of the stored list, ascending, valid below list_len.
  logic signed [VAL_W-1:0] list_vals [CAPACITY];
  int                      list_len;
  result_t                 awaited_q [$];
  int                      mismatches = 0;

  // Apply one command word to the shadow list and return the result word it gives.
  function automatic result_t apply_word(input item_t w);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // A new value lands in front of any equal values already stored.
          pos = 0;
          while (pos < list_len && list_vals[pos] < w.value) pos++;
          for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = w.value;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(w.index) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(w.index); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      ACT_READ: begin
        if (int'(w.index) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_vals[w.index];
        end
      end
      default: begin
        // The spare action code leaves the list alone.
      end
    endcase
    r.entry_count = OUT_CNT_W'(list_len);
    return r;
  endfunction

  // Result words are matched before command words so that a result can never be
  // paired with the command accepted on the same edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      list_len = 0;
      awaited_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result word: value %0d status %0d count %0d",
                     $realtime, rsp.read_value, rsp.status, rsp.entry_count);
          end
        end else begin
          want = awaited_q.pop_front();
          if (want.read_value !== rsp.read_value || want.status !== rsp.status ||
              want.entry_count !== rsp.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result word differs: expected value %0d status %0d count %0d,",
                       $realtime, want.read_value, want.status, want.entry_count);
              $display("  got value %0d status %0d count %0d",
                       rsp.read_value, rsp.status, rsp.entry_count);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) awaited_q.push_back(apply_word(cmd));
    end
    fail_count <= mismatches;
    pending    <= awaited_q.size();
  end

endmodule

// ===== tb/tb_sorted_list_engine.sv =====
// Top of the sorted list engine testbench: clock, reset, command words and result stalls.
// Prediction and comparison live in sle_order_check; depends on sle_pkg and the RTL.
module tb_sorted_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam int          CAPACITY     = 16;
  localparam int          RANDOM_WORDS = 1950;
  localparam logic [1:0]  ACT_SPARE    = 2'd3;

  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_SPOTTY, DRAIN_HOLD, DRAIN_TOGGLE} drain_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  item_t       cmd       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  result_t     rsp;
  int          fail_count;
  int          pending;
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;

  always #6 clk = ~clk;

  sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  sle_order_check #(.CAPACITY(CAPACITY)) u_order_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The result side stalls in stretches: free, scattered, solid or alternating.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      drain_left <= 0;
    end else if (drain_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 3));
      drain_left <= $urandom_range(4, 40);
      rsp_stall  <= 1'b0;
    end else begin
      drain_left <= drain_left - 1;
      case (drain_mode)
        DRAIN_FREE:   rsp_stall <= 1'b0;
        DRAIN_SPOTTY: rsp_stall <= ($urandom_range(0, 2) == 0);
        DRAIN_HOLD:   rsp_stall <= 1'b1;
        default:      rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  function automatic item_t make_word(input logic [1:0] action, input logic signed [31:0] value,
                                      input int index);
    item_t w;
    w.action = action;
    w.value  = value;
    w.index  = IDX_W'(index);
    return w;
  endfunction

  // Values cluster around zero for duplicates, hit the extremes, or span the range.
  function automatic logic signed [31:0] pick_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 32'(signed'($urandom_range(0, 16)) - 8);
    if (pick == 4) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return -32'sd1;
        3: return 32'sd0;
        4: return 32'sh8000_0001;
        default: return 32'sh7FFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  // Present one command word and hold it until the engine takes it.
  task automatic send_word(input item_t w);
    cmd       <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Stop sending and wait until every awaited result word has been taken.
  task automatic drain_all();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Stimulus: directed words first, then random bursts shaped by insert-heavy
  // and remove-heavy phases so the list both fills up and empties out.
  initial begin
    int          sent;
    int          burst_len;
    int          phase_left;
    int          insert_pct;
    int          roll;
    int          i;
    logic [1:0]  action;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: read and remove refused, spare code ignored.
    send_word(make_word(ACT_READ, 32'sd5, 0));
    send_word(make_word(ACT_REMOVE, 32'sd0, 0));
    send_word(make_word(ACT_SPARE, 32'sd0, 0));
    // Extremes and equal values.
    send_word(make_word(ACT_INSERT, 32'sh7FFF_FFFF, 0));
    send_word(make_word(ACT_INSERT, 32'sh8000_0000, 255));
    send_word(make_word(ACT_INSERT, 32'sd0, 0));
    send_word(make_word(ACT_INSERT, 32'sd0, 0));
    send_word(make_word(ACT_INSERT, -32'sd1, 0));
    for (i = 0; i <= 5; i++) send_word(make_word(ACT_READ, 32'sd0, i));
    send_word(make_word(ACT_READ, 32'sd0, 255));
    send_word(make_word(ACT_REMOVE, 32'sd0, 255));
    send_word(make_word(ACT_REMOVE, 32'sd0, 2));
    send_word(make_word(ACT_REMOVE, 32'sd0, 0));
    send_word(make_word(ACT_SPARE, 32'shFFFF_FFFF, 255));
    // Fill to capacity, then two inserts too many.
    for (i = 0; i < CAPACITY - 2; i++) send_word(make_word(ACT_INSERT, pick_value(), 0));
    send_word(make_word(ACT_INSERT, 32'sd1, 0));
    send_word(make_word(ACT_READ, 32'sd0, CAPACITY - 1));
    send_word(make_word(ACT_READ, 32'sd0, CAPACITY));
    drain_all();

    // Random part, counting every word except those with the spare action code.
    sent       = 0;
    phase_left = 0;
    insert_pct = 50;
    while (sent < RANDOM_WORDS) begin
      burst_len = $urandom_range(1, 24);
      while (burst_len > 0 && sent < RANDOM_WORDS) begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(40, 120);
          case ($urandom_range(0, 2))
            0:       insert_pct = 80;
            1:       insert_pct = 50;
            default: insert_pct = 25;
          endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) action = ACT_SPARE;
        else if (roll < insert_pct) action = ACT_INSERT;
        else if (roll[0]) action = ACT_REMOVE;
        else action = ACT_READ;
        send_word(make_word(action, pick_value(),
                            ($urandom_range(0, 99) < 85) ? $urandom_range(0, CAPACITY + 1)
                                                         : $urandom_range(0, 255)));
        if (action != ACT_SPARE) sent++;
        phase_left--;
        burst_len--;
        // Halfway through, let the engine run dry once.
        if (sent == RANDOM_WORDS / 2 && action != ACT_SPARE) begin
          drain_all();
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    drain_all();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
